// ===== design/tsr_pkg.sv =====
package tsr_pkg;

    localparam int COORD_W = 12;
    localparam int ROW_W   = 6;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_coord vert0_x;
        t_coord vert0_y;
        t_coord vert1_x;
        t_coord vert1_y;
        t_coord vert2_x;
        t_coord vert2_y;
    } t_tri;

    typedef struct packed {
        logic [ROW_W-1:0] span_row;
        t_coord           span_first;
        t_coord           span_final;
        logic             span_last;
    } t_span;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic setup;
        logic step;
        logic next_edge;
        logic mark;
        logic scan;
        logic scan_next;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_range;
        logic walk_end;
        logic last_edge;
        logic row_valid;
        logic scan_end;
        logic scan_last;
        logic out_free;
    } t_stat;

endpackage

// ===== design/triangle_span_rasterizer.sv =====
// Triangle span rasterizer. A word on the input carries one triangle as three
// signed 12-bit vertices; the block walks all three sides with a Bresenham
// stepper, records the minimum and maximum column per row, then delivers one
// span word per covered row in ascending row order with span_last set on the
// final one. A triangle with no point on rows 0 to HEIGHT-1 yields no words.
// Input is taken only while the block is idle, so one triangle is in flight
// at a time. Each edge has a setup step, then per visited point a read then
// an update of the single ported row memory when the point lies on a table
// row, and a single step otherwise. The readout then visits the rows in
// order, passing over each empty row and emitting each covered row, up to
// the last covered row, or through all HEIGHT rows when none is covered; a
// covered row waits while the output register has not been taken. The
// finished span waits in an output register, so the next triangle can be
// taken while it is pending.
module triangle_span_rasterizer import tsr_pkg::*; #(
    parameter int HEIGHT = 64
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_tri  i_tri,
    output logic  o_valid,
    input  logic  i_stall,
    output t_span o_span
);

    t_cmd  cmd;
    t_stat stat;
    logic  busy;

    tsr_control u_control (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    tsr_datapath #(
        .HEIGHT (HEIGHT)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tri   (i_tri),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_span  (o_span),
        .o_valid (o_valid),
        .i_stall (i_stall)
    );

    assign o_stall = busy;

endmodule

// ===== design/tsr_datapath.sv =====
module tsr_datapath import tsr_pkg::*; #(
    parameter int HEIGHT = 64
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_tri  i_tri,
    input  t_cmd  i_cmd,
    output t_stat o_stat,
    output t_span o_span,
    output logic  o_valid,
    input  logic  i_stall
);

    localparam int AW = (HEIGHT > 1) ? $clog2(HEIGHT) : 1;
    localparam logic [1:0] EDGE_LAST = 2'd2;

    t_tri                r_tri;
    logic [1:0]          r_edge;
    t_coord              r_x;
    t_coord              r_y;
    logic [12:0]         r_err;
    logic [11:0]         r_major;
    logic [11:0]         r_minor;
    logic [12:0]         r_count;
    logic signed [1:0]   r_sx;
    logic signed [1:0]   r_sy;
    logic                r_ymaj;
    logic [HEIGHT-1:0]   r_valid;
    logic [AW-1:0]       r_scan;
    logic [2*COORD_W-1:0] r_mem [HEIGHT];
    logic [2*COORD_W-1:0] r_rd;
    t_span               r_out;
    logic                r_out_valid;

    t_coord              xa, ya, xb, yb;
    logic signed [12:0]  ddx, ddy;
    logic [11:0]         adx, ady;
    logic signed [1:0]   sgx, sgy;
    logic                ymaj;
    logic [11:0]         major, minor;

    logic [12:0]         sum;
    logic                take_minor;
    logic signed [1:0]   inc_x, inc_y;

    logic [AW-1:0]       addr;
    logic                cur_valid;
    t_coord              old_left, old_right, new_left, new_right;
    logic                above;
    logic                out_free;

    // Edge endpoint selection and Bresenham setup.
    always_comb begin
        case (r_edge)
            2'd0: begin
                xa = r_tri.vert0_x; ya = r_tri.vert0_y;
                xb = r_tri.vert1_x; yb = r_tri.vert1_y;
            end
            2'd1: begin
                xa = r_tri.vert1_x; ya = r_tri.vert1_y;
                xb = r_tri.vert2_x; yb = r_tri.vert2_y;
            end
            default: begin
                xa = r_tri.vert2_x; ya = r_tri.vert2_y;
                xb = r_tri.vert0_x; yb = r_tri.vert0_y;
            end
        endcase
        ddx = $signed({xb[11], xb}) - $signed({xa[11], xa});
        ddy = $signed({yb[11], yb}) - $signed({ya[11], ya});
        adx = ddx[12] ? 12'(-ddx) : ddx[11:0];
        ady = ddy[12] ? 12'(-ddy) : ddy[11:0];
        sgx = (ddx == '0) ? 2'sb00 : (ddx[12] ? 2'sb11 : 2'sb01);
        sgy = (ddy == '0) ? 2'sb00 : (ddy[12] ? 2'sb11 : 2'sb01);
        ymaj  = adx < ady;
        major = ymaj ? ady : adx;
        minor = ymaj ? adx : ady;
    end

    // One step of the walker: the major axis always moves, the minor axis moves
    // when the error term plus the minor delta reaches the major delta.
    always_comb begin
        sum        = r_err + {1'b0, r_minor};
        take_minor = sum >= {1'b0, r_major};
        inc_x      = (take_minor || !r_ymaj) ? r_sx : 2'sb00;
        inc_y      = (take_minor ||  r_ymaj) ? r_sy : 2'sb00;
    end

    assign addr      = i_cmd.scan ? r_scan : r_y[AW-1:0];
    assign cur_valid = r_valid[addr];
    assign old_left  = r_rd[2*COORD_W-1:COORD_W];
    assign old_right = r_rd[COORD_W-1:0];

    always_comb begin
        new_left  = (!cur_valid || (r_x < old_left))  ? r_x : old_left;
        new_right = (!cur_valid || (r_x > old_right)) ? r_x : old_right;
    end

    // Any filled row beyond the one being read out.
    always_comb begin
        above = 1'b0;
        for (int i = 0; i < HEIGHT; i++) begin
            if (r_valid[i] && (AW'(i) > r_scan)) begin
                above = 1'b1;
            end
        end
    end

    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        o_stat.in_range  = !r_y[11] && (r_y < 12'(HEIGHT));
        o_stat.walk_end  = r_count == 13'd1;
        o_stat.last_edge = r_edge == EDGE_LAST;
        o_stat.row_valid = cur_valid;
        o_stat.scan_end  = r_scan == AW'(HEIGHT - 1);
        o_stat.scan_last = !above;
        o_stat.out_free  = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tri <= i_tri;
        end
        if (i_cmd.setup) begin
            r_x     <= xa;
            r_y     <= ya;
            r_major <= major;
            r_minor <= minor;
            r_err   <= {2'b00, minor[11:1]};
            r_count <= {1'b0, major} + 13'd1;
            r_sx    <= sgx;
            r_sy    <= sgy;
            r_ymaj  <= ymaj;
        end else if (i_cmd.step) begin
            r_x     <= r_x + {{(COORD_W-2){inc_x[1]}}, inc_x};
            r_y     <= r_y + {{(COORD_W-2){inc_y[1]}}, inc_y};
            r_err   <= take_minor ? (sum - {1'b0, r_major}) : sum;
            r_count <= r_count - 13'd1;
        end
    end

    // Row extent memory: one read and one write port, read data registered.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mark) begin
            r_mem[addr] <= {new_left, new_right};
        end
        r_rd <= r_mem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge  <= '0;
            r_valid <= '0;
            r_scan  <= '0;
        end else begin
            if (i_cmd.load) begin
                r_edge  <= '0;
                r_valid <= '0;
                r_scan  <= '0;
            end else begin
                if (i_cmd.next_edge) begin
                    r_edge <= r_edge + 2'd1;
                end
                if (i_cmd.mark) begin
                    r_valid[addr] <= 1'b1;
                end
                if (i_cmd.scan_next) begin
                    r_scan <= r_scan + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.span_row   <= ROW_W'(r_scan);
            r_out.span_first <= old_left;
            r_out.span_final <= old_right;
            r_out.span_last  <= !above;
        end
    end

    assign o_span  = r_out;
    assign o_valid = r_out_valid;

    // The walker never steps past its final point.
    a_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_count != '0))
        else $error("walker stepped with an exhausted point count");

    // A marked point always leaves at least one filled row.
    a_mark_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mark |=> (r_valid != '0))
        else $error("row mark did not set a valid bit");

endmodule

// ===== design/tsr_control.sv =====
module tsr_control import tsr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_PT    = 3'd2;
    localparam logic [2:0] S_MARK  = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = S_PT;
            end
            S_PT, S_MARK: begin
                // Points on rows outside the table are stepped over without a row update.
                if (r_state == S_PT && i_stat.in_range) begin
                    n_state = S_MARK;
                end else begin
                    o_cmd.mark = (r_state == S_MARK);
                    o_cmd.step = 1'b1;
                    if (!i_stat.walk_end) begin
                        n_state = S_PT;
                    end else if (i_stat.last_edge) begin
                        n_state = S_SCAN;
                    end else begin
                        o_cmd.next_edge = 1'b1;
                        n_state         = S_SETUP;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.row_valid) begin
                    n_state = S_EMIT;
                end else if (i_stat.scan_end) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            S_EMIT: begin
                o_cmd.scan = 1'b1;
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_stat.scan_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.scan_next = 1'b1;
                        n_state         = S_SCAN;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = r_state != S_IDLE;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_stat.out_free)
        else $error("span loaded over a word still waiting");

    a_mark_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MARK) |-> i_stat.in_range)
        else $error("row update issued for a row outside the table");

    a_emit_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> i_stat.row_valid)
        else $error("span emitted for an empty row");

endmodule

// ===== tb/tb_triangle_span_rasterizer.sv =====
`timescale 1ns / 1ps

module tb_triangle_span_rasterizer;
    import tsr_pkg::*;

    localparam int HEIGHT        = 64;
    localparam int MAX_WAIT      = 13;
    // A full-range triangle walks about three times 4096 points before its readout.
    localparam int SETTLE_CYCLES = 30000;
    localparam int PRINT_LIMIT   = 100;

    typedef enum int {
        SHAPE_ONSCREEN,
        SHAPE_WIDE_X,
        SHAPE_OFFSCREEN,
        SHAPE_DEGENERATE,
        SHAPE_ANYWHERE
    } t_shape;

    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    logic  i_stall = 1'b0;
    t_tri  i_tri   = '0;
    logic  o_stall;
    logic  o_valid;
    t_span o_span;

    int    error_count   = 0;
    int    send_gap_max  = MAX_WAIT;
    int    stall_max     = MAX_WAIT;
    int    stall_left    = 0;

    // Per-row coverage table of the triangle most recently accepted.
    int    row_min [HEIGHT];
    int    row_max [HEIGHT];
    bit    row_hit [HEIGHT];
    t_span expected_spans [$];

    triangle_span_rasterizer #(
        .HEIGHT (HEIGHT)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_tri   (i_tri),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_span  (o_span)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT) begin
            $display("ERROR at %0t: %s", $time, msg);
        end
        error_count++;
    endtask

    function automatic int sign_of(input int v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function automatic int abs_of(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic void mark_column(input int x, input int y);
        if (y >= 0 && y < HEIGHT) begin
            if (!row_hit[y]) begin
                row_hit[y] = 1'b1;
                row_min[y] = x;
                row_max[y] = x;
            end else begin
                if (x < row_min[y]) row_min[y] = x;
                if (x > row_max[y]) row_max[y] = x;
            end
        end
    endfunction

    function automatic void walk_edge(input int xa, input int ya, input int xb, input int yb);
        int step_x, step_y, major, minor, axial_x, axial_y, x, y, err, count;
        step_x  = sign_of(xb - xa);
        step_y  = sign_of(yb - ya);
        major   = abs_of(xb - xa);
        minor   = abs_of(yb - ya);
        axial_x = step_x;
        axial_y = 0;
        if (major < minor) begin
            major   = abs_of(yb - ya);
            minor   = abs_of(xb - xa);
            axial_x = 0;
            axial_y = step_y;
        end
        x   = xa;
        y   = ya;
        err = minor / 2;
        for (count = major + 1; count > 0; count--) begin
            mark_column(x, y);
            err += minor;
            if (err < major) begin
                x += axial_x;
                y += axial_y;
            end else begin
                err -= major;
                x += step_x;
                y += step_y;
            end
        end
    endfunction

    function automatic void trace_triangle(input t_tri triangle);
        int    x0, y0, x1, y1, x2, y2, r, last_row;
        t_span span;
        x0 = $signed(triangle.vert0_x);
        y0 = $signed(triangle.vert0_y);
        x1 = $signed(triangle.vert1_x);
        y1 = $signed(triangle.vert1_y);
        x2 = $signed(triangle.vert2_x);
        y2 = $signed(triangle.vert2_y);
        for (r = 0; r < HEIGHT; r++) row_hit[r] = 1'b0;
        walk_edge(x0, y0, x1, y1);
        walk_edge(x1, y1, x2, y2);
        walk_edge(x2, y2, x0, y0);
        last_row = -1;
        for (r = 0; r < HEIGHT; r++) begin
            if (row_hit[r]) last_row = r;
        end
        for (r = 0; r < HEIGHT; r++) begin
            if (row_hit[r]) begin
                span.span_row   = r[ROW_W-1:0];
                span.span_first = row_min[r][COORD_W-1:0];
                span.span_final = row_max[r][COORD_W-1:0];
                span.span_last  = (r == last_row);
                expected_spans.push_back(span);
            end
        end
    endfunction

    function automatic t_coord coord(input int v);
        if (v < -2048) v = -2048;
        if (v > 2047)  v = 2047;
        return v[COORD_W-1:0];
    endfunction

    function automatic t_tri make_tri(input int x0, input int y0, input int x1,
                                      input int y1, input int x2, input int y2);
        t_tri triangle;
        triangle.vert0_x = coord(x0);
        triangle.vert0_y = coord(y0);
        triangle.vert1_x = coord(x1);
        triangle.vert1_y = coord(y1);
        triangle.vert2_x = coord(x2);
        triangle.vert2_y = coord(y2);
        return triangle;
    endfunction

    // Mostly short edges near the table, so that the walks stay cheap; a few go anywhere.
    function automatic t_tri random_triangle();
        t_shape shape;
        int     pick, bx, by, dx, dy, k, variant;
        int     xs [3];
        int     ys [3];
        pick = $urandom_range(0, 99);
        if (pick < 55)      shape = SHAPE_ONSCREEN;
        else if (pick < 72) shape = SHAPE_WIDE_X;
        else if (pick < 84) shape = SHAPE_OFFSCREEN;
        else if (pick < 97) shape = SHAPE_DEGENERATE;
        else                shape = SHAPE_ANYWHERE;
        bx = int'($urandom_range(0, 4095)) - 2048;
        case (shape)
            SHAPE_ONSCREEN: begin
                for (k = 0; k < 3; k++) begin
                    xs[k] = int'($urandom_range(0, 100)) - 20;
                    ys[k] = int'($urandom_range(0, 83)) - 10;
                end
            end
            SHAPE_WIDE_X: begin
                for (k = 0; k < 3; k++) begin
                    xs[k] = bx + int'($urandom_range(0, 80)) - 40;
                    ys[k] = int'($urandom_range(0, 83)) - 10;
                end
            end
            SHAPE_OFFSCREEN: begin
                if ($urandom_range(0, 1) != 0) by = -int'($urandom_range(21, 300));
                else                           by = int'($urandom_range(84, 320));
                for (k = 0; k < 3; k++) begin
                    xs[k] = bx + int'($urandom_range(0, 80)) - 40;
                    ys[k] = by + int'($urandom_range(0, 40)) - 20;
                end
            end
            SHAPE_DEGENERATE: begin
                bx      = int'($urandom_range(0, 100)) - 20;
                by      = int'($urandom_range(0, 83)) - 10;
                dx      = int'($urandom_range(0, 30)) - 15;
                dy      = int'($urandom_range(0, 30)) - 15;
                variant = $urandom_range(0, 2);
                xs[0] = bx;
                ys[0] = by;
                xs[1] = (variant == 0) ? bx : bx + dx;
                ys[1] = (variant == 0) ? by : by + dy;
                xs[2] = (variant == 0) ? bx : ((variant == 1) ? bx : bx + 2 * dx);
                ys[2] = (variant == 0) ? by : ((variant == 1) ? by : by + 2 * dy);
                if (variant == 1) begin
                    // Two coincident vertices, the third somewhere else.
                    xs[1] = bx;
                    ys[1] = by;
                    xs[2] = bx + dx;
                    ys[2] = by + dy;
                end
            end
            default: begin
                for (k = 0; k < 3; k++) begin
                    xs[k] = int'($urandom_range(0, 4095)) - 2048;
                    ys[k] = int'($urandom_range(0, 4095)) - 2048;
                end
            end
        endcase
        return make_tri(xs[0], ys[0], xs[1], ys[1], xs[2], ys[2]);
    endfunction

    // Holds valid until the word is taken, then records the spans it must produce.
    task automatic send_triangle(input t_tri triangle);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_tri   <= triangle;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        trace_triangle(triangle);
    endtask

    always @(posedge i_clk) begin : drive_stall
        int gap;
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (o_valid && !i_stall) begin
            gap = $urandom_range(0, stall_max);
            stall_left <= gap;
            i_stall    <= (gap != 0);
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= (stall_left > 1);
        end
    end

    always @(posedge i_clk) begin : check_spans
        t_span want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_spans.size() == 0) begin
                report_mismatch($sformatf("unexpected span word on row %0d", o_span.span_row));
            end else begin
                want = expected_spans.pop_front();
                if (o_span.span_row !== want.span_row)
                    report_mismatch($sformatf("span_row: got %0d, want %0d",
                                              o_span.span_row, want.span_row));
                if (o_span.span_first !== want.span_first)
                    report_mismatch($sformatf("span_first on row %0d: got %0d, want %0d",
                                              want.span_row, $signed(o_span.span_first),
                                              $signed(want.span_first)));
                if (o_span.span_final !== want.span_final)
                    report_mismatch($sformatf("span_final on row %0d: got %0d, want %0d",
                                              want.span_row, $signed(o_span.span_final),
                                              $signed(want.span_final)));
                if (o_span.span_last !== want.span_last)
                    report_mismatch($sformatf("span_last on row %0d: got %0b, want %0b",
                                              want.span_row, o_span.span_last,
                                              want.span_last));
            end
        end
    end

    task automatic test_extremes();
        send_triangle(make_tri(-2048, -2048, 2047, 2047, -2048, 2047));
        send_triangle(make_tri(2047, -2048, -2048, 2047, 2047, 2047));
        send_triangle(make_tri(-2048, 10, 2047, 10, 0, 40));
        send_triangle(make_tri(2047, 63, -2048, 0, 2047, 0));
        send_triangle(make_tri(2047, 2047, 2047, 2047, 2047, 2047));
        send_triangle(make_tri(-2048, -2048, -2048, -2048, -2048, -2048));
    endtask

    // Edges that leave the table through row 0 or past the last row, or end on those rows.
    task automatic test_row_clipping();
        send_triangle(make_tri(5, -20, 30, 10, -10, 5));
        send_triangle(make_tri(10, 50, 40, 90, 0, 70));
        send_triangle(make_tri(0, 0, 20, 63, -5, 63));
    endtask

    task automatic test_nothing_visible();
        send_triangle(make_tri(0, -1, 50, -1, 20, -40));
        send_triangle(make_tri(0, 64, 30, 100, -30, 64));
    endtask

    task automatic test_degenerate();
        send_triangle(make_tri(7, 20, 7, 20, 7, 20));
        send_triangle(make_tri(-3, 0, -3, 0, -3, 0));
        send_triangle(make_tri(100, 63, 100, 63, 100, 63));
        send_triangle(make_tri(10, 10, 10, 10, 30, 40));
        send_triangle(make_tri(-5, 30, 5, 30, 20, 30));
        send_triangle(make_tri(12, 5, 12, 50, 12, 20));
        send_triangle(make_tri(0, 0, 10, 10, 20, 20));
        send_triangle(make_tri(0, 0, 3, 40, 40, 3));
    endtask

    // Every row of the table covered, so the readout delivers its largest set of words.
    task automatic test_full_height();
        send_triangle(make_tri(0, -5, 30, 70, -30, 70));
        send_triangle(make_tri(-100, 0, 100, 63, 0, 63));
    endtask

    task automatic test_random_triangles(input int count);
        int n;
        for (n = 0; n < count; n++) begin
            if (n % 20 == 0) begin
                send_gap_max = ($urandom_range(0, 1) != 0) ? MAX_WAIT : 0;
                stall_max    = ($urandom_range(0, 1) != 0) ? MAX_WAIT : 0;
            end
            send_triangle(random_triangle());
        end
    endtask

    task automatic test_back_to_back(input int count);
        int n;
        send_gap_max = 0;
        stall_max    = 0;
        for (n = 0; n < count; n++) send_triangle(random_triangle());
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_extremes();
        test_row_clipping();
        test_nothing_visible();
        test_degenerate();
        test_full_height();
        test_random_triangles(140);
        test_back_to_back(20);

        i_valid <= 1'b0;
        stall_max = MAX_WAIT;
        while (expected_spans.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_spans.size() != 0)
            report_mismatch($sformatf("%0d span words never arrived", expected_spans.size()));

        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
